### hdl/kmp_stream_matcher_assert.svh
// Assertion macros for the streaming pattern matcher.
// KMP_ASSERT checks an implication at the same clock edge; KMP_ASSERT_NEXT
// checks that a condition leads to a consequence at the following edge.
// Both expect clk_i and rst_ni to be visible where they are used.
`ifndef KMP_STREAM_MATCHER_ASSERT_SVH
`define KMP_STREAM_MATCHER_ASSERT_SVH

`ifndef SYNTH
`define KMP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define KMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KMP_ASSERT(lbl, ante, cons, msg)
`define KMP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### hdl/kmp_pkg.sv
`default_nettype none

package kmp_pkg;

  localparam int unsigned MAX_PATTERN = 64;
  localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned POS_W = 32;

  typedef enum logic [1:0] {
    FUNC_CLEAR    = 2'd0,
    FUNC_APPEND   = 2'd1,
    FUNC_NEW_TEXT = 2'd2,
    FUNC_TEXT     = 2'd3
  } func_e;

  // Write request into the row of pattern cells.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [7:0]       sym;
    logic [LEN_W-1:0] fail;
  } kmp_wr_t;

  // Read request: the pattern byte and the failure value are looked up at
  // separate cells.
  typedef struct packed {
    logic [IDX_W-1:0] sym_idx;
    logic [IDX_W-1:0] fail_idx;
  } kmp_rd_t;

endpackage

`default_nettype wire

### hdl/kmp_if.sv
`default_nettype none

interface kmp_in_if;
  import kmp_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] symbol;

  modport source (output valid, func, symbol, input ready);
  modport sink   (input valid, func, symbol, output ready);
endinterface

interface kmp_out_if;
  import kmp_pkg::*;

  logic             valid;
  logic             ready;
  logic             match_found;
  logic [POS_W-1:0] match_start;
  logic             refused;

  modport source (output valid, match_found, match_start, refused, input ready);
  modport sink   (input valid, match_found, match_start, refused, output ready);
endinterface

`default_nettype wire

### hdl/kmp_cell.sv
`default_nettype none

// One pattern position: holds its byte and its failure value. The read
// buses run through the row; a cell whose index is addressed ORs its own
// contents onto the bus it hands to its neighbour.
module kmp_cell (
  input  wire logic                    clk_i,
  input  wire logic [kmp_pkg::IDX_W-1:0] cell_idx_i,
  input  wire kmp_pkg::kmp_wr_t        wr_i,
  input  wire kmp_pkg::kmp_rd_t        rd_i,
  input  wire logic [7:0]              sym_chain_i,
  input  wire logic [kmp_pkg::LEN_W-1:0] fail_chain_i,
  output logic [7:0]                   sym_chain_o,
  output logic [kmp_pkg::LEN_W-1:0]    fail_chain_o
);
  import kmp_pkg::*;

  logic [7:0]       sym_q;
  logic [LEN_W-1:0] fail_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.idx == cell_idx_i)) begin
      sym_q  <= wr_i.sym;
      fail_q <= wr_i.fail;
    end
  end

  assign sym_chain_o  = sym_chain_i  | ((rd_i.sym_idx == cell_idx_i) ? sym_q : 8'd0);
  assign fail_chain_o = fail_chain_i | ((rd_i.fail_idx == cell_idx_i) ? fail_q : '0);

endmodule

`default_nettype wire

### hdl/kmp_stream_matcher.sv
// Streaming pattern matcher (Knuth-Morris-Pratt).
// Requests arrive on in_i (valid/ready, fields func and symbol); every
// accepted request yields exactly one response on out_o (match_found,
// match_start, refused), in order. func selects clear pattern, append a
// pattern byte, start a new text, or a text byte.
// Clear, start-new-text, the first pattern byte, a refused byte and a text
// byte against an empty pattern are answered at once: the response is
// registered at the accepting edge. Any other pattern or text byte goes
// to S_CHECK, which follows the failure links one at a time, because the
// pattern byte and failure value of the next prefix length come from a
// registered read of the cell row.
// Reset clears the pattern length, the match state, the text position and
// the response valid flag; the cell contents and the response payload are
// left as they are, and the cells are only read below the pattern length.
// A response waits in the output register while the receiver stalls; the
// next request is accepted in the same cycle the waiting response is taken.
`default_nettype none
`include "kmp_stream_matcher_assert.svh"

module kmp_stream_matcher (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  kmp_in_if.sink    in_i,
  kmp_out_if.source out_o
);
  import kmp_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_CHECK
  } state_e;

  // Control state.
  state_e           state_q, state_d;
  logic [LEN_W-1:0] len_q, len_d;         // pattern bytes held
  logic [LEN_W-1:0] bpl_q, bpl_d;         // failure value of the last byte
  logic [LEN_W-1:0] matched_q, matched_d; // prefix length matched in text
  logic [POS_W-1:0] pos_q, pos_d;         // text bytes seen, saturating
  logic             text_q, text_d;       // walk serves a text byte
  logic             out_valid_q, out_valid_d;

  // Working registers of the failure walk.
  logic [LEN_W-1:0] k_q, k_d;
  logic [7:0]       sym_q, sym_d;

  // Response payload.
  logic             found_q, found_d;
  logic [POS_W-1:0] start_q, start_d;
  logic             refused_q, refused_d;

  // Registered read data from the cell row, valid for k_q in S_CHECK.
  logic [7:0]       rd_sym_q;
  logic [LEN_W-1:0] rd_fail_q;

  kmp_wr_t wr;
  kmp_rd_t rd;
  logic    accept;
  logic    load_out;
  logic    walk;
  logic    hit;
  logic [LEN_W-1:0] kn;
  logic [POS_W-1:0] pos_inc;
  func_e   func;

  logic [7:0]       sym_chain  [MAX_PATTERN+1];
  logic [LEN_W-1:0] fail_chain [MAX_PATTERN+1];

  assign func        = func_e'(in_i.func);
  assign in_i.ready  = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign accept      = in_i.valid && in_i.ready;

  assign out_o.valid       = out_valid_q;
  assign out_o.match_found = found_q;
  assign out_o.match_start = start_q;
  assign out_o.refused     = refused_q;

  // Comparison of the current prefix length against the stored byte.
  assign walk = (k_q != '0) && (k_q < LEN_W'(MAX_PATTERN)) && (rd_sym_q != sym_q);
  assign hit  = (k_q < LEN_W'(MAX_PATTERN)) && (rd_sym_q == sym_q);
  assign kn   = hit ? (k_q + LEN_W'(1)) : k_q;

  assign pos_inc = (pos_q == {POS_W{1'b1}}) ? pos_q : (pos_q + POS_W'(1));

  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    bpl_d     = bpl_q;
    matched_d = matched_q;
    pos_d     = pos_q;
    text_d    = text_q;
    k_d       = k_q;
    sym_d     = sym_q;
    load_out  = 1'b0;
    found_d   = 1'b0;
    start_d   = '0;
    refused_d = 1'b0;
    wr.en     = 1'b0;
    wr.idx    = len_q[IDX_W-1:0];
    wr.sym    = sym_q;
    wr.fail   = kn;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          sym_d = in_i.symbol;
          unique case (func)
            FUNC_CLEAR: begin
              len_d     = '0;
              bpl_d     = '0;
              matched_d = '0;
              load_out  = 1'b1;
            end
            FUNC_APPEND: begin
              if (len_q >= LEN_W'(MAX_PATTERN)) begin
                refused_d = 1'b1;
                load_out  = 1'b1;
              end else if (len_q == '0) begin
                // The first byte has no proper prefix to extend.
                wr.en    = 1'b1;
                wr.sym   = in_i.symbol;
                wr.fail  = '0;
                bpl_d    = '0;
                len_d    = LEN_W'(1);
                load_out = 1'b1;
              end else begin
                k_d     = bpl_q;
                text_d  = 1'b0;
                state_d = S_CHECK;
              end
            end
            FUNC_NEW_TEXT: begin
              matched_d = '0;
              pos_d     = '0;
              load_out  = 1'b1;
            end
            FUNC_TEXT: begin
              if (len_q == '0) begin
                pos_d    = pos_inc;
                load_out = 1'b1;
              end else begin
                k_d     = matched_q;
                text_d  = 1'b1;
                state_d = S_CHECK;
              end
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        if (walk) begin
          k_d = rd_fail_q;
        end else if (!text_q) begin
          wr.en    = 1'b1;
          bpl_d    = kn;
          len_d    = len_q + LEN_W'(1);
          load_out = 1'b1;
          state_d  = S_IDLE;
        end else begin
          if (kn >= len_q) begin
            // Complete occurrence: report it and fall back along the
            // failure link of the last pattern byte.
            found_d   = 1'b1;
            start_d   = pos_q - (POS_W'(len_q) - POS_W'(1));
            matched_d = bpl_q;
          end else begin
            matched_d = kn;
          end
          pos_d    = pos_inc;
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = (out_valid_q && !out_o.ready) || load_out;
  end

  // The cell row is read at the prefix length of the next cycle.
  assign rd.sym_idx  = k_d[IDX_W-1:0];
  assign rd.fail_idx = IDX_W'(k_d - LEN_W'(1));

  assign sym_chain[0]  = 8'd0;
  assign fail_chain[0] = '0;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    kmp_cell u_cell (
      .clk_i        (clk_i),
      .cell_idx_i   (IDX_W'(i)),
      .wr_i         (wr),
      .rd_i         (rd),
      .sym_chain_i  (sym_chain[i]),
      .fail_chain_i (fail_chain[i]),
      .sym_chain_o  (sym_chain[i+1]),
      .fail_chain_o (fail_chain[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      bpl_q       <= '0;
      matched_q   <= '0;
      pos_q       <= '0;
      text_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      bpl_q       <= bpl_d;
      matched_q   <= matched_d;
      pos_q       <= pos_d;
      text_q      <= text_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    sym_q     <= sym_d;
    rd_sym_q  <= sym_chain[MAX_PATTERN];
    rd_fail_q <= fail_chain[MAX_PATTERN];
    if (load_out) begin
      found_q   <= found_d;
      start_q   <= start_d;
      refused_q <= refused_d;
    end
  end

  // A response never both reports a match and a refused pattern byte.
  `KMP_ASSERT(a_found_refused_excl, out_valid_q, !(found_q && refused_q), "match and refusal together")
  // The walk only ever looks at prefixes shorter than the pattern.
  `KMP_ASSERT(a_walk_in_pattern, state_q == S_CHECK, k_q < len_q, "walk beyond pattern length")
  // With no pattern there can be no partial match and no build state.
  `KMP_ASSERT(a_empty_pattern, len_q == '0, (bpl_q == '0) && (matched_q == '0), "stale match state")
  // A finished walk always leaves a response waiting.
  `KMP_ASSERT_NEXT(a_walk_responds, (state_q == S_CHECK) && !walk, out_valid_q && (state_q == S_IDLE), "walk ended without response")

endmodule

`default_nettype wire

### verif/kmp_stream_matcher_tb.sv
`default_nettype none

// Self-checking bench for the streaming pattern matcher.
//
// Every request accepted on the input channel is run through a predictor of
// the matcher right away, at the accepting clock edge. The predicted response
// is queued, and each response taken from the output channel is compared,
// field by field, with the oldest entry of that queue. Requests are driven at
// the falling clock edge and both channels are sampled at the rising edge.
// Neither side changes a signal close to the edge at which it is sampled.
module kmp_stream_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kmp_pkg::*;

  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned RANDOM_REQUESTS = 1250;
  // Allows for the slowest request, which follows failure links one at a time.
  localparam int unsigned SETTLE_CYCLES   = 2 * MAX_PATTERN + 8;
  localparam int unsigned DRAIN_LIMIT     = 50000;

  typedef struct packed {
    logic             match_found;
    logic [POS_W-1:0] match_start;
    logic             refused;
  } search_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  kmp_in_if  in_if ();
  kmp_out_if out_if ();

  kmp_stream_matcher i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // The predictor's own copy of the matcher state. The pattern bytes and
  // failure links start unknown, just as the cells of the block do; only
  // entries below the pattern length are ever read.
  logic [7:0]       pat_bytes  [MAX_PATTERN];
  logic [LEN_W-1:0] fail_links [MAX_PATTERN];
  logic [LEN_W-1:0] pat_len    = '0;
  logic [LEN_W-1:0] border_len = '0;
  logic [LEN_W-1:0] match_len  = '0;
  logic [POS_W-1:0] text_pos   = '0;

  search_result_t search_result_q [$];

  int unsigned requests_sent     = 0;
  int unsigned responses_checked = 0;
  int unsigned matches_seen      = 0;
  int unsigned refusals_seen     = 0;
  int unsigned mismatches        = 0;

  // Controls shared between the test tasks, the sender and the receiver.
  bit          gaps_enabled  = 1'b1;
  int unsigned burst_left    = 0;
  bit          hold_off_req  = 1'b0;

  // Follow failure links from prefix length k until byte c extends the
  // prefix, then take the step forward if it does.
  function automatic logic [LEN_W-1:0] walk_failure(logic [LEN_W-1:0] k, logic [7:0] c);
    while (k > 0 && k < MAX_PATTERN && pat_bytes[k] != c) begin
      k = fail_links[k - 1];
    end
    if (k < MAX_PATTERN && pat_bytes[k] == c) begin
      k = k + 1'b1;
    end
    return k;
  endfunction

  // Apply one request to the predictor state and return the response that
  // the matcher must give for it.
  function automatic search_result_t kmp_step(func_e f, logic [7:0] c);
    search_result_t r;
    logic [LEN_W-1:0] k;
    r = '0;
    case (f)
      FUNC_CLEAR: begin
        // The text position survives a clear of the pattern.
        pat_len    = '0;
        border_len = '0;
        match_len  = '0;
      end
      FUNC_APPEND: begin
        if (pat_len >= MAX_PATTERN) begin
          r.refused = 1'b1;
        end else begin
          k = (pat_len > 0) ? walk_failure(border_len, c) : '0;
          pat_bytes[pat_len]  = c;
          fail_links[pat_len] = k;
          border_len          = k;
          pat_len             = pat_len + 1'b1;
        end
      end
      FUNC_NEW_TEXT: begin
        match_len = '0;
        text_pos  = '0;
      end
      FUNC_TEXT: begin
        // With an empty pattern a text byte only moves the position on.
        if (pat_len > 0) begin
          k = walk_failure(match_len, c);
          if (k >= pat_len) begin
            r.match_found = 1'b1;
            r.match_start = text_pos - POS_W'(pat_len - 1'b1);
            k             = fail_links[pat_len - 1'b1];
          end
          match_len = k;
        end
        if (text_pos != '1) begin
          text_pos = text_pos + 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // Monitor and scoreboard. The response is taken first: a response is
  // registered, so it can never belong to a request accepted at the same
  // edge.
  always @(posedge clk_i) begin
    search_result_t exp_r;
    search_result_t pred_r;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        responses_checked++;
        if (out_if.match_found === 1'b1) matches_seen++;
        if (out_if.refused === 1'b1) refusals_seen++;
        if (search_result_q.size() == 0) begin
          mismatches++;
          $display("%0t: response with no request outstanding: found %0b start %0d refused %0b",
                   $time, out_if.match_found, out_if.match_start, out_if.refused);
        end else begin
          exp_r = search_result_q.pop_front();
          if (out_if.match_found !== exp_r.match_found) begin
            mismatches++;
            $display("%0t: match_found expected %0b actual %0b",
                     $time, exp_r.match_found, out_if.match_found);
          end
          if (out_if.match_start !== exp_r.match_start) begin
            mismatches++;
            $display("%0t: match_start expected %0d actual %0d",
                     $time, exp_r.match_start, out_if.match_start);
          end
          if (out_if.refused !== exp_r.refused) begin
            mismatches++;
            $display("%0t: refused expected %0b actual %0b",
                     $time, exp_r.refused, out_if.refused);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        pred_r = kmp_step(func_e'(in_if.func), in_if.symbol);
        search_result_q = {search_result_q, pred_r};
      end
    end
  end

  // Receiver. It switches between a few stall patterns of random length,
  // one of which never stalls. When a test asks for it, ready is held low
  // for a long count of cycles so that the output register fills and the
  // matcher has to stall its input.
  initial begin
    int unsigned run_left;
    int unsigned mode;
    int unsigned held;
    out_if.ready = 1'b0;
    run_left = 0;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_if.ready = 1'b0;
        for (held = 1; held < HOLD_OFF_CYCLES; held++) begin
          @(negedge clk_i);
        end
        hold_off_req = 1'b0;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(8, 80);
          mode = $urandom_range(0, 3);
        end
        run_left--;
        case (mode)
          0: out_if.ready = 1'b1;
          1: out_if.ready = run_left[0];
          2: out_if.ready = ($urandom_range(0, 3) != 0);
          default: out_if.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one request and wait until it is accepted. In burst mode the
  // sender goes quiet for a random gap whenever a burst is used up. Valid is
  // only lowered for a gap, never between two requests of one burst.
  task automatic send_request(input func_e f, input logic [7:0] sym);
    int unsigned gap;
    if (gaps_enabled) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(1, 6);
        @(negedge clk_i);
        in_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left--;
    end
    @(negedge clk_i);
    in_if.valid  = 1'b1;
    in_if.func   = f;
    in_if.symbol = sym;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    requests_sent++;
  endtask

  // A short hand-made stream: text against an empty pattern, overlapping
  // occurrences, ignored symbols on clear and new text, a clear that keeps
  // the text position, and a pattern that grows while text is under way.
  task automatic test_directed_cases();
    send_request(FUNC_TEXT,     8'h00);
    send_request(FUNC_TEXT,     8'hFF);
    send_request(FUNC_APPEND,   8'h61);
    send_request(FUNC_APPEND,   8'h61);
    send_request(FUNC_TEXT,     8'h61);
    send_request(FUNC_TEXT,     8'h61);
    send_request(FUNC_TEXT,     8'h61);
    send_request(FUNC_TEXT,     8'h62);
    send_request(FUNC_CLEAR,    8'hFF);
    send_request(FUNC_APPEND,   8'h00);
    send_request(FUNC_APPEND,   8'hFF);
    send_request(FUNC_TEXT,     8'h00);
    // The pattern grows by one byte while one byte of it is matched.
    send_request(FUNC_APPEND,   8'h00);
    send_request(FUNC_TEXT,     8'hFF);
    send_request(FUNC_TEXT,     8'h00);
    send_request(FUNC_TEXT,     8'hFF);
    send_request(FUNC_TEXT,     8'h00);
    send_request(FUNC_NEW_TEXT, 8'hA5);
    send_request(FUNC_TEXT,     8'h00);
    send_request(FUNC_TEXT,     8'hFF);
    send_request(FUNC_TEXT,     8'h00);
    send_request(FUNC_CLEAR,    8'h00);
    send_request(FUNC_TEXT,     8'h00);
  endtask

  // Fill the pattern store to the last cell, check that further bytes are
  // refused, then find the full-length pattern at least twice in a text.
  task automatic test_store_full();
    logic [7:0] pat [MAX_PATTERN];
    int unsigned i;
    send_request(FUNC_CLEAR, 8'h00);
    for (i = 0; i < MAX_PATTERN; i++) begin
      pat[i] = ($urandom_range(0, 3) == 0) ? 8'hA5 : 8'h5A;
      send_request(FUNC_APPEND, pat[i]);
    end
    send_request(FUNC_APPEND, 8'h00);
    send_request(FUNC_APPEND, 8'hFF);
    send_request(FUNC_NEW_TEXT, 8'h00);
    for (i = 0; i < 2 * MAX_PATTERN + 3; i++) begin
      send_request(FUNC_TEXT, pat[i % MAX_PATTERN]);
    end
  endtask

  // Hold the receiver off for a long stretch while the sender keeps
  // offering requests back to back.
  task automatic test_output_hold_off();
    int unsigned i;
    gaps_enabled = 1'b0;
    send_request(FUNC_CLEAR, 8'h00);
    send_request(FUNC_APPEND, 8'h33);
    send_request(FUNC_APPEND, 8'hCC);
    send_request(FUNC_APPEND, 8'h33);
    hold_off_req = 1'b1;
    send_request(FUNC_NEW_TEXT, 8'h00);
    for (i = 0; i < 36; i++) begin
      send_request(FUNC_TEXT, ($urandom_range(0, 1) != 0) ? 8'h33 : 8'hCC);
    end
    gaps_enabled = 1'b1;
  endtask

  // Random streams. Most are well formed: a clear, a pattern over a small
  // random alphabet, often a new text, then text that often copies the
  // pattern so that matches are frequent. Some text requests are replaced
  // by a further pattern byte or a request of random kind. The rest of the
  // streams are pure noise.
  task automatic test_random_streams();
    logic [7:0]  alpha [4];
    logic [7:0]  pat   [MAX_PATTERN + 2];
    int unsigned n_alpha;
    int unsigned plen;
    int unsigned tlen;
    int unsigned sel;
    int unsigned pidx;
    int unsigned i;
    int unsigned stop_at;
    stop_at = requests_sent + RANDOM_REQUESTS;
    while (requests_sent < stop_at) begin
      gaps_enabled = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_request(func_e'($urandom_range(0, 3)), 8'($urandom()));
        end
      end else begin
        n_alpha = $urandom_range(1, 4);
        for (i = 0; i < n_alpha; i++) alpha[i] = 8'($urandom());
        sel = $urandom_range(0, 49);
        if (sel == 0) plen = $urandom_range(MAX_PATTERN - 4, MAX_PATTERN + 2);
        else if (sel < 5) plen = $urandom_range(7, 20);
        else plen = $urandom_range(1, 6);
        send_request(FUNC_CLEAR, 8'($urandom()));
        for (i = 0; i < plen; i++) begin
          pat[i] = alpha[$urandom_range(0, n_alpha - 1)];
          send_request(FUNC_APPEND, pat[i]);
        end
        if ($urandom_range(0, 3) != 0) send_request(FUNC_NEW_TEXT, 8'($urandom()));
        tlen = $urandom_range(8, 40) + ((plen > 6) ? 2 * plen : 0);
        pidx = 0;
        for (i = 0; i < tlen; i++) begin
          sel = $urandom_range(0, 99);
          if (sel < 3) begin
            send_request(FUNC_APPEND, alpha[$urandom_range(0, n_alpha - 1)]);
          end else if (sel < 5) begin
            send_request(func_e'($urandom_range(0, 3)), 8'($urandom()));
          end else if (sel < 10) begin
            send_request(FUNC_TEXT, 8'($urandom()));
          end else if (sel < 55) begin
            send_request(FUNC_TEXT, pat[pidx]);
            pidx = ($urandom_range(0, 9) == 0) ? 0 : (pidx + 1) % plen;
          end else begin
            send_request(FUNC_TEXT, alpha[$urandom_range(0, n_alpha - 1)]);
          end
        end
      end
    end
    gaps_enabled = 1'b1;
  endtask

  // Sequence of tests, end of run and the final verdict.
  initial begin
    int unsigned drain_cycles;
    in_if.valid  = 1'b0;
    in_if.func   = FUNC_CLEAR;
    in_if.symbol = 8'h00;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_store_full();
    test_output_hold_off();
    test_random_streams();

    @(negedge clk_i);
    in_if.valid = 1'b0;

    // Wait for every outstanding response, then a little longer in case a
    // stray response is still on its way.
    drain_cycles = 0;
    while (search_result_q.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    if (search_result_q.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, search_result_q.size());
      $display("Regression FAIL");
    end else begin
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      $display("Sent %0d requests and checked %0d responses, %0d of them matches",
               requests_sent, responses_checked, matches_seen);
      $display("and %0d refused pattern bytes; %0d field mismatches were found.",
               refusals_seen, mismatches);
      if (mismatches == 0 && search_result_q.size() == 0) begin
        $display("Regression PASS");
      end else begin
        $display("Regression FAIL");
      end
    end
    $finish;
  end

  // Watchdog: the slowest legal run takes well under a tenth of this.
  initial begin
    #10_000_000;
    $display("%0t: watchdog expired", $time);
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
